[src/rsc_pkg.sv]
// shared types, constants and helpers for the register slot cache
package rsc_pkg;

  localparam int SLOTS     = 21;
  localparam int FIRST_REG = 5;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OFF_W     = 16;
  localparam int REG_W     = 5;
  localparam int AGE_W     = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_INVAL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_GRANT  = 3'd0,
    KIND_STORE  = 3'd1,
    KIND_LOAD   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_FLUSH,
    CMD_INVAL,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [OFF_W-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } cmd_chan_t;

  typedef struct packed {
    kind_t             kind;
    logic [REG_W-1:0]  reg_number;
    logic [OFF_W-1:0]  mem_offset;
    logic              hit;
    logic              last;
  } result_t;

  function automatic logic [REG_W-1:0] reg_of(logic [SLOT_W-1:0] slot);
    return REG_W'(FIRST_REG + int'(slot));
  endfunction

endpackage

[src/register_slot_cache_lru.sv]
// top level of the register slot cache: request queue feeding the cache engine
//
// Fully associative write-back cache mapping nonzero frame offsets onto 21
// register slots (registers 5 to 25) with LRU replacement. Both sides are
// queues: push/full in, empty/pop out. A rejected request, an invalidate or a
// hit gives its result from the EXEC state; a miss with a free slot goes
// through FILL (which gives a read's load) and then GRANT; a miss with all
// slots busy scans one age stamp a cycle over slots 1 to 20 in SCAN, then
// stores a dirty victim in EVICT before FILL and GRANT. A flush walks the
// slots one per cycle, holding on a slot whose store finds the output queue
// full, and then gives its done result. The engine works on one request at a
// time, so it takes no new request before the last one's final result. Results
// leave one per cycle through a two-entry output queue while the receiver
// pops, and the request queue holds two items while the engine works.
module register_slot_cache_lru (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_op,
  input  logic signed [15:0]  in_offset,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_kind,
  output logic [4:0]          out_reg_number,
  output logic signed [15:0]  out_mem_offset,
  output logic                out_hit,
  output logic                out_last
);
  import rsc_pkg::*;

  cmd_chan_t  cmd;
  logic       cmd_pop;
  result_t    res;

  rsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_offset (in_offset),
    .cmd_o     (cmd),
    .cmd_pop   (cmd_pop)
  );

  rsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .cmd_pop   (cmd_pop),
    .res_o     (res),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_kind       = res.kind;
  assign out_reg_number = res.reg_number;
  assign out_mem_offset = res.mem_offset;
  assign out_hit        = res.hit;
  assign out_last       = res.last;

endmodule

[src/rsc_front.sv]
// request intake: classifies requests and queues them for the cache engine
module rsc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_op,
  input  logic signed [15:0]            in_offset,
  output rsc_pkg::cmd_chan_t            cmd_o,
  input  logic                          cmd_pop
);
  import rsc_pkg::*;

  cmd_t        q_r [2];
  logic        rd_ptr_r, rd_ptr_nxt;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        cmd_in;
  logic        push_ok, pop_ok;

  always_comb begin
    cmd_in.offset = in_offset;
    case (op_t'(in_op))
      OP_READ:  cmd_in.kind = (in_offset == '0) ? CMD_REJECT : CMD_READ;
      OP_WRITE: cmd_in.kind = (in_offset == '0) ? CMD_REJECT : CMD_WRITE;
      OP_FLUSH: cmd_in.kind = CMD_FLUSH;
      OP_INVAL: cmd_in.kind = CMD_INVAL;
      default:  cmd_in.kind = CMD_REJECT;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && (cnt_r != 2'd0);
  assign cmd_o.valid = (cnt_r != 2'd0);
  assign cmd_o.cmd   = q_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/rsc_back.sv]
// cache engine: slot tags, dirty bits, age stamps, victim search and result queue
module rsc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsc_pkg::cmd_chan_t   cmd_i,
  output logic                 cmd_pop,
  output rsc_pkg::result_t     res_o,
  output logic                 out_empty,
  input  logic                 out_pop
);
  import rsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_EVICT, ST_FILL, ST_GRANT, ST_FLUSH, ST_DONE
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   vic_r, vic_nxt;
  logic [AGE_W-1:0]    best_age_r, best_age_nxt;
  logic [AGE_W-1:0]    age_cnt_r, age_cnt_nxt;
  logic [OFF_W-1:0]    slot_off_r   [SLOTS];
  logic [OFF_W-1:0]    slot_off_nxt [SLOTS];
  logic                slot_dirty_r   [SLOTS];
  logic                slot_dirty_nxt [SLOTS];
  logic [AGE_W-1:0]    slot_age_r   [SLOTS];
  logic [AGE_W-1:0]    slot_age_nxt [SLOTS];

  result_t             oq_r [2];
  logic                orp_r, orp_nxt;
  logic                owp_r, owp_nxt;
  logic [1:0]          ocnt_r, ocnt_nxt;

  logic [SLOTS-1:0]    hit_vec, free_vec;
  logic [SLOT_W-1:0]   hit_idx, free_idx;
  logic                hit_any, free_any;
  logic [AGE_W-1:0]    stamp;
  logic                space, emit, opop, need_store;
  result_t             res;

  // parallel tag compare and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i]  = (slot_off_r[i] == cmd_r.offset);
      free_vec[i] = (slot_off_r[i] == '0);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SLOT_W'(i);
      if (free_vec[i]) free_idx = SLOT_W'(i);
    end
  end

  assign hit_any    = |hit_vec;
  assign free_any   = |free_vec;
  assign stamp      = (age_cnt_r == '1) ? age_cnt_r : age_cnt_r + 1'b1;
  assign space      = (ocnt_r != 2'd2);
  assign need_store = slot_dirty_r[idx_r] && (slot_off_r[idx_r] != '0);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    vic_nxt        = vic_r;
    best_age_nxt   = best_age_r;
    age_cnt_nxt    = age_cnt_r;
    slot_off_nxt   = slot_off_r;
    slot_dirty_nxt = slot_dirty_r;
    slot_age_nxt   = slot_age_r;
    cmd_pop        = 1'b0;
    emit           = 1'b0;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_i.cmd;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r.kind)
          CMD_REJECT: begin
            if (space) begin
              emit      = 1'b1;
              res.kind  = KIND_REJECT;
              res.last  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          CMD_INVAL: begin
            if (space) begin
              emit           = 1'b1;
              res.kind       = KIND_DONE;
              res.mem_offset = cmd_r.offset;
              res.last       = 1'b1;
              for (int i = 0; i < SLOTS; i++) begin
                slot_off_nxt[i]   = '0;
                slot_dirty_nxt[i] = 1'b0;
                slot_age_nxt[i]   = '0;
              end
              state_nxt = ST_IDLE;
            end
          end
          CMD_FLUSH: begin
            idx_nxt   = '0;
            state_nxt = ST_FLUSH;
          end
          CMD_READ, CMD_WRITE: begin
            if (hit_any) begin
              if (space) begin
                emit                  = 1'b1;
                res.kind              = KIND_GRANT;
                res.reg_number        = reg_of(hit_idx);
                res.mem_offset        = cmd_r.offset;
                res.hit               = 1'b1;
                res.last              = 1'b1;
                slot_age_nxt[hit_idx] = stamp;
                age_cnt_nxt           = stamp;
                if (cmd_r.kind == CMD_WRITE) slot_dirty_nxt[hit_idx] = 1'b1;
                state_nxt = ST_IDLE;
              end
            end else if (free_any) begin
              vic_nxt   = free_idx;
              state_nxt = ST_FILL;
            end else begin
              // all slots busy: walk the age stamps for the oldest one
              vic_nxt      = '0;
              best_age_nxt = slot_age_r[0];
              idx_nxt      = SLOT_W'(1);
              state_nxt    = (SLOTS > 1) ? ST_SCAN : ST_EVICT;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (slot_age_r[idx_r] < best_age_r) begin
          vic_nxt      = idx_r;
          best_age_nxt = slot_age_r[idx_r];
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_EVICT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EVICT: begin
        if (slot_dirty_r[vic_r] && (slot_off_r[vic_r] != '0)) begin
          if (space) begin
            emit           = 1'b1;
            res.kind       = KIND_STORE;
            res.reg_number = reg_of(vic_r);
            res.mem_offset = slot_off_r[vic_r];
            state_nxt      = ST_FILL;
          end
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if ((cmd_r.kind == CMD_WRITE) || space) begin
          slot_off_nxt[vic_r]   = cmd_r.offset;
          slot_dirty_nxt[vic_r] = (cmd_r.kind == CMD_WRITE);
          slot_age_nxt[vic_r]   = stamp;
          age_cnt_nxt           = stamp;
          if (cmd_r.kind != CMD_WRITE) begin
            emit           = 1'b1;
            res.kind       = KIND_LOAD;
            res.reg_number = reg_of(vic_r);
            res.mem_offset = cmd_r.offset;
          end
          state_nxt = ST_GRANT;
        end
      end
      ST_GRANT: begin
        if (space) begin
          emit           = 1'b1;
          res.kind       = KIND_GRANT;
          res.reg_number = reg_of(vic_r);
          res.mem_offset = cmd_r.offset;
          res.last       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!need_store || space) begin
          if (need_store) begin
            emit           = 1'b1;
            res.kind       = KIND_STORE;
            res.reg_number = reg_of(idx_r);
            res.mem_offset = slot_off_r[idx_r];
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (space) begin
          emit           = 1'b1;
          res.kind       = KIND_DONE;
          res.mem_offset = cmd_r.offset;
          res.last       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // two-entry result queue
  assign opop      = out_pop && (ocnt_r != 2'd0);
  assign out_empty = (ocnt_r == 2'd0);
  assign res_o     = oq_r[orp_r];

  always_comb begin
    orp_nxt = opop ? ~orp_r : orp_r;
    owp_nxt = emit ? ~owp_r : owp_r;
    case ({emit, opop})
      2'b10:   ocnt_nxt = ocnt_r + 2'd1;
      2'b01:   ocnt_nxt = ocnt_r - 2'd1;
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    vic_r      <= vic_nxt;
    best_age_r <= best_age_nxt;
    if (emit) begin
      oq_r[owp_r] <= res;
    end
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      age_cnt_r <= '0;
      orp_r     <= 1'b0;
      owp_r     <= 1'b0;
      ocnt_r    <= 2'd0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_off_r[i]   <= '0;
        slot_dirty_r[i] <= 1'b0;
        slot_age_r[i]   <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      age_cnt_r    <= age_cnt_nxt;
      orp_r        <= orp_nxt;
      owp_r        <= owp_nxt;
      ocnt_r       <= ocnt_nxt;
      slot_off_r   <= slot_off_nxt;
      slot_dirty_r <= slot_dirty_nxt;
      slot_age_r   <= slot_age_nxt;
    end
  end

`ifndef SYNTH
  // a nonzero offset lives in at most one slot; offset zero matches every free slot
  a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cmd_r.offset != '0) |-> $onehot0(hit_vec))
    else $error("offset cached in more than one slot");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.last) |=> (state_r == ST_IDLE))
    else $error("engine still busy after final result");

  a_inval_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cmd_r.kind == CMD_INVAL && emit) |=> (&free_vec))
    else $error("slot still valid after invalidate");

  a_age_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (age_cnt_r >= $past(age_cnt_r)))
    else $error("age counter went backward");
`endif

endmodule

[sim/register_slot_cache_lru_tb.sv]
// testbench for the register slot cache: directed table, then random traffic vs a predictor
`timescale 1ns / 1ps

module register_slot_cache_lru_tb;
  import rsc_pkg::*;

  localparam int N_DIR      = 15;
  localparam int RAND_ITEMS = 100;
  localparam int CALM_ITEMS = 20;
  localparam int POOL       = 32;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    op_t              op;
    logic [OFF_W-1:0] offset;
    bit               typed;
    result_t          res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_op = OP_READ;
  logic signed [15:0] in_offset = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [2:0]         out_kind;
  logic [4:0]         out_reg_number;
  logic signed [15:0] out_mem_offset;
  logic               out_hit;
  logic               out_last;

  // shadow copy of the cache
  logic [OFF_W-1:0] slot_tag     [SLOTS];
  logic             slot_dirty_q [SLOTS];
  logic [AGE_W-1:0] slot_stamp   [SLOTS];
  logic [AGE_W-1:0] stamp_ctr;

  result_t          step_results[$];
  result_t          awaited_results[$];
  logic [OFF_W-1:0] offset_pool[POOL];
  bit               calm = 1'b0;
  int               mismatches = 0;

  // typed rows hold the single result; the rest take their results from the predictor, which all rows pass through
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_READ,  16'h0000, 1'b1, '{KIND_REJECT, 5'd0, 16'h0000, 1'b0, 1'b1}},
    '{OP_WRITE, 16'h0000, 1'b1, '{KIND_REJECT, 5'd0, 16'h0000, 1'b0, 1'b1}},
    '{OP_FLUSH, 16'h0000, 1'b1, '{KIND_DONE,   5'd0, 16'h0000, 1'b0, 1'b1}},
    '{OP_WRITE, 16'h7fff, 1'b1, '{KIND_GRANT,  5'd5, 16'h7fff, 1'b0, 1'b1}},
    '{OP_WRITE, 16'h8000, 1'b1, '{KIND_GRANT,  5'd6, 16'h8000, 1'b0, 1'b1}},
    '{OP_READ,  16'h7fff, 1'b1, '{KIND_GRANT,  5'd5, 16'h7fff, 1'b1, 1'b1}},
    '{OP_READ,  16'h0001, 1'b0, '0},
    '{OP_READ,  16'hffff, 1'b0, '0},
    '{OP_WRITE, 16'h0001, 1'b0, '0},
    '{OP_FLUSH, 16'h5555, 1'b0, '0},
    '{OP_FLUSH, 16'hffff, 1'b0, '0},
    '{OP_INVAL, 16'haaaa, 1'b1, '{KIND_DONE,   5'd0, 16'haaaa, 1'b0, 1'b1}},
    '{OP_FLUSH, 16'h7fff, 1'b1, '{KIND_DONE,   5'd0, 16'h7fff, 1'b0, 1'b1}},
    '{OP_READ,  16'h8000, 1'b0, '0},
    '{OP_INVAL, 16'h0000, 1'b1, '{KIND_DONE,   5'd0, 16'h0000, 1'b0, 1'b1}}
  };

  register_slot_cache_lru dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_offset      (in_offset),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_reg_number (out_reg_number),
    .out_mem_offset (out_mem_offset),
    .out_hit        (out_hit),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [REG_W-1:0] slot_reg(int s);
    return REG_W'(FIRST_REG + s);
  endfunction

  function automatic logic [AGE_W-1:0] bump_stamp();
    if (stamp_ctr != '1) stamp_ctr++;
    return stamp_ctr;
  endfunction

  function automatic void note_result(kind_t k, logic [REG_W-1:0] r, logic [OFF_W-1:0] m,
                                      logic h, logic l);
    step_results.push_back('{k, r, m, h, l});
  endfunction

  function automatic void clear_slots();
    foreach (slot_tag[i]) begin
      slot_tag[i]     = '0;
      slot_dirty_q[i] = 1'b0;
      slot_stamp[i]   = '0;
    end
  endfunction

  // fills step_results with what one request produces and updates the shadow cache
  task automatic predict_access(op_t op, logic [OFF_W-1:0] off);
    int s;
    step_results.delete();
    if (op == OP_FLUSH) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_dirty_q[i] && slot_tag[i] != 0)
          note_result(KIND_STORE, slot_reg(i), slot_tag[i], 1'b0, 1'b0);
      note_result(KIND_DONE, '0, off, 1'b0, 1'b1);
      return;
    end
    if (op == OP_INVAL) begin
      clear_slots();
      note_result(KIND_DONE, '0, off, 1'b0, 1'b1);
      return;
    end
    if (off == 0) begin
      note_result(KIND_REJECT, '0, '0, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_tag[i] == off) begin
        slot_stamp[i] = bump_stamp();
        if (op == OP_WRITE) slot_dirty_q[i] = 1'b1;
        note_result(KIND_GRANT, slot_reg(i), off, 1'b1, 1'b1);
        return;
      end
    end
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_tag[i] == 0 && s < 0) s = i;
    if (s < 0) begin
      // lru victim, ties go to the lowest slot
      s = 0;
      for (int i = 1; i < SLOTS; i++)
        if (slot_stamp[i] < slot_stamp[s]) s = i;
      if (slot_dirty_q[s] && slot_tag[s] != 0)
        note_result(KIND_STORE, slot_reg(s), slot_tag[s], 1'b0, 1'b0);
    end
    slot_tag[s]     = off;
    slot_dirty_q[s] = (op == OP_WRITE);
    slot_stamp[s]   = bump_stamp();
    if (op != OP_WRITE) note_result(KIND_LOAD, slot_reg(s), off, 1'b0, 1'b0);
    note_result(KIND_GRANT, slot_reg(s), off, 1'b0, 1'b1);
  endtask

  task automatic push_request(op_t op, logic [OFF_W-1:0] off, bit typed, result_t typed_res);
    @(negedge clk);
    in_push   <= 1'b1;
    in_op     <= op;
    in_offset <= off;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_access(op, off);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
  endtask

  task automatic sender_gap();
    int n;
    if (calm || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 10);
    @(negedge clk);
    in_push   <= 1'b0;
    in_op     <= 2'($urandom_range(0, 3));
    in_offset <= 16'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected transfer: kind %0d reg %0d offset 0x%0h", out_kind,
               out_reg_number, out_mem_offset);
        mismatches++;
      end else begin
        exp_r = awaited_results.pop_front();
        compare_field("kind", exp_r.kind, out_kind);
        compare_field("reg_number", exp_r.reg_number, out_reg_number);
        compare_field("mem_offset", exp_r.mem_offset, $unsigned(out_mem_offset));
        compare_field("hit", exp_r.hit, out_hit);
        compare_field("last", exp_r.last, out_last);
      end
    end
  end

  // receiver with bursty stalls
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 10);
      if (calm) stall_left = 0;
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    op_t              op;
    logic [OFF_W-1:0] off;
    int               pick;
    clear_slots();
    stamp_ctr = '0;
    foreach (offset_pool[i]) begin
      offset_pool[i] = 16'($urandom);
      if (offset_pool[i] == 0) offset_pool[i] = 16'h0100;
    end
    offset_pool[0] = 16'h8000;
    offset_pool[1] = 16'h7fff;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      push_request(dir_rows[r].op, dir_rows[r].offset, dir_rows[r].typed, dir_rows[r].res);
      sender_gap();
    end

    // mostly reads and writes over a pool a bit larger than the cache, so
    // hits, fills and evictions of clean and dirty victims all show up
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      if (n == RAND_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      op   = op_t'($urandom_range(0, 1));
      if (pick < 80) begin
        off = offset_pool[$urandom_range(0, POOL - 1)];
      end else if (pick < 86) begin
        op  = OP_FLUSH;
        off = 16'($urandom);
      end else if (pick < 88) begin
        op  = OP_INVAL;
        off = 16'($urandom);
      end else if (pick < 92) begin
        off = '0;
      end else begin
        off = 16'($urandom);
      end
      push_request(op, off, 1'b0, '0);
      sender_gap();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
